>>> sv/sfpa_pkg.sv
// Shared types and constants for the striped flash page allocator.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package sfpa_pkg;

   localparam int ModeWidth   = 2;
   localparam int StatusWidth = 2;

   // request opcodes
   typedef enum logic [ModeWidth-1:0] {
      MODE_ALLOC = 2'd0,
      MODE_ERASE = 2'd1,
      MODE_WRITE = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   // per-block status codes held in the status memory
   typedef enum logic [StatusWidth-1:0] {
      ST_UNINIT  = 2'd0,
      ST_ERASED  = 2'd1,
      ST_BAD     = 2'd2,
      ST_WRITTEN = 2'd3
   } status_type;

   // cursor unit commands
   typedef enum logic [1:0] {
      CUR_HOLD = 2'd0,
      CUR_STEP = 2'd1,
      CUR_BACK = 2'd2
   } cur_cmd_type;

   // width of a field that counts 0 .. n-1, at least one bit
   function automatic int fld_width(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

`default_nettype wire

>>> sv/sfpa_channels.sv
// Request and response channel interfaces (valid/ready with payload).
// Depends on sfpa_pkg for the mode and status field widths.
`default_nettype none

interface sfpa_req_if #(
   parameter int CW = 1,
   parameter int BW = 3,
   parameter int HW = 3,
   parameter int KW = 10,
   parameter int PW = 8
) ();
   logic                           valid;
   logic                           ready;
   logic [sfpa_pkg::ModeWidth-1:0] mode;
   logic [CW-1:0]                  card;
   logic [BW-1:0]                  bus;
   logic [HW-1:0]                  chip;
   logic [KW-1:0]                  block;
   logic [PW-1:0]                  page;
   logic                           erase_failed;

   modport source (output valid, mode, card, bus, chip, block, page, erase_failed,
                   input ready);
   modport sink   (input valid, mode, card, bus, chip, block, page, erase_failed,
                   output ready);
endinterface

interface sfpa_rsp_if #(
   parameter int CW = 1,
   parameter int BW = 3,
   parameter int HW = 3,
   parameter int KW = 10,
   parameter int PW = 8
) ();
   logic                             valid;
   logic                             ready;
   logic [CW-1:0]                    alloc_card;
   logic [BW-1:0]                    alloc_bus;
   logic [HW-1:0]                    alloc_chip;
   logic [KW-1:0]                    alloc_block;
   logic [PW-1:0]                    alloc_page;
   logic                             bad_block_hit;
   logic                             already_written;
   logic                             no_erased_block;
   logic [sfpa_pkg::StatusWidth-1:0] prior_status;

   modport source (output valid, alloc_card, alloc_bus, alloc_chip, alloc_block,
                   alloc_page, bad_block_hit, already_written, no_erased_block,
                   prior_status, input ready);
   modport sink   (input valid, alloc_card, alloc_bus, alloc_chip, alloc_block,
                   alloc_page, bad_block_hit, already_written, no_erased_block,
                   prior_status, output ready);
endinterface

`default_nettype wire

>>> sv/sfpa_status_mem.sv
// Block status memory: one write port, one read port with registered data.
// Depends on sfpa_pkg for the status width.
`default_nettype none

module sfpa_status_mem #(
   parameter int AW = 17
) (
   input  wire logic                             clock,
   input  wire logic                             we,
   input  wire logic [AW-1:0]                    waddr,
   input  wire logic [sfpa_pkg::StatusWidth-1:0] wdata,
   input  wire logic [AW-1:0]                    raddr,
   output      logic [sfpa_pkg::StatusWidth-1:0] rdata
);

   logic [sfpa_pkg::StatusWidth-1:0] status_ff [0:(1<<AW)-1];
   logic [sfpa_pkg::StatusWidth-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         status_ff[waddr] <= wdata;
      end
      rdata_ff <= status_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> sv/sfpa_cursor.sv
// Striping cursor: mixed-radix counter over card, bus, chip, block, page
// (card fastest) with a one-step-back copy. Depends on sfpa_pkg.
`default_nettype none

module sfpa_cursor #(
   parameter int CARDS  = 2,
   parameter int BUSES  = 8,
   parameter int CHIPS  = 8,
   parameter int BLOCKS = 1024,
   parameter int PAGES  = 256,
   localparam int CW = sfpa_pkg::fld_width(CARDS),
   localparam int BW = sfpa_pkg::fld_width(BUSES),
   localparam int HW = sfpa_pkg::fld_width(CHIPS),
   localparam int KW = sfpa_pkg::fld_width(BLOCKS),
   localparam int PW = sfpa_pkg::fld_width(PAGES)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire sfpa_pkg::cur_cmd_type       cmd,
   output      logic [CW-1:0]               cur_card,
   output      logic [BW-1:0]               cur_bus,
   output      logic [HW-1:0]               cur_chip,
   output      logic [KW-1:0]               cur_block,
   output      logic [PW-1:0]               cur_page
);

   logic [CW-1:0] cc_ff, lc_ff, cc_in;
   logic [BW-1:0] cb_ff, lb_ff, cb_in;
   logic [HW-1:0] ch_ff, lh_ff, ch_in;
   logic [KW-1:0] ck_ff, lk_ff, ck_in;
   logic [PW-1:0] cp_ff, lp_ff, cp_in;
   logic c_last, b_last, h_last, k_last, p_last;
   logic [CW-1:0] c_nx;
   logic [BW-1:0] b_nx;
   logic [HW-1:0] h_nx;
   logic [KW-1:0] k_nx;
   logic [PW-1:0] p_nx;

   // one advance step: each digit wraps and carries into the next
   always_comb begin
      c_last = (cc_ff == CW'(CARDS - 1));
      b_last = (cb_ff == BW'(BUSES - 1));
      h_last = (ch_ff == HW'(CHIPS - 1));
      k_last = (ck_ff == KW'(BLOCKS - 1));
      p_last = (cp_ff == PW'(PAGES - 1));
      c_nx = c_last ? '0 : cc_ff + 1'b1;
      b_nx = cb_ff;
      h_nx = ch_ff;
      k_nx = ck_ff;
      p_nx = cp_ff;
      if (c_last) begin
         b_nx = b_last ? '0 : cb_ff + 1'b1;
         if (b_last) begin
            h_nx = h_last ? '0 : ch_ff + 1'b1;
            if (h_last) begin
               k_nx = k_last ? '0 : ck_ff + 1'b1;
               if (k_last) begin
                  p_nx = p_last ? '0 : cp_ff + 1'b1;
               end
            end
         end
      end
   end

   // select next cursor
   always_comb begin
      cc_in = cc_ff;
      cb_in = cb_ff;
      ch_in = ch_ff;
      ck_in = ck_ff;
      cp_in = cp_ff;
      case (cmd)
         sfpa_pkg::CUR_HOLD: begin
         end
         sfpa_pkg::CUR_STEP: begin
            cc_in = c_nx;
            cb_in = b_nx;
            ch_in = h_nx;
            ck_in = k_nx;
            cp_in = p_nx;
         end
         sfpa_pkg::CUR_BACK: begin
            cc_in = lc_ff;
            cb_in = lb_ff;
            ch_in = lh_ff;
            ck_in = lk_ff;
            cp_in = lp_ff;
         end
         default: begin
         end
      endcase
   end

   // cursor registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff <= '0;
         cb_ff <= '0;
         ch_ff <= '0;
         ck_ff <= '0;
         cp_ff <= '0;
      end else begin
         cc_ff <= cc_in;
         cb_ff <= cb_in;
         ch_ff <= ch_in;
         ck_ff <= ck_in;
         cp_ff <= cp_in;
      end
   end

   // keep the position left behind by each step
   always_ff @(posedge clock) begin
      if (cmd == sfpa_pkg::CUR_STEP) begin
         lc_ff <= cc_ff;
         lb_ff <= cb_ff;
         lh_ff <= ch_ff;
         lk_ff <= ck_ff;
         lp_ff <= cp_ff;
      end
   end

   assign cur_card  = cc_ff;
   assign cur_bus   = cb_ff;
   assign cur_chip  = ch_ff;
   assign cur_block = ck_ff;
   assign cur_page  = cp_ff;

endmodule

`default_nettype wire

>>> sv/striped_flash_page_allocator_top.sv
// Striped flash page allocator top: sequencer, status memory, cursor unit.
// Erase/write: read, look and finish states, then the response register; a new
// request is taken only in idle. Allocate: the cursor takes 1 .. cards*buses*
// chips*blocks steps to the next erased block; the walk checks one block per
// cycle, set by the single read port of the status memory. Reset clears the
// status memory, one entry a cycle, 2**17 entries by default.
`default_nettype none

module striped_flash_page_allocator_top #(
   parameter int CARDS  = 2,
   parameter int BUSES  = 8,
   parameter int CHIPS  = 8,
   parameter int BLOCKS = 1024,
   parameter int PAGES  = 256
) (
   input wire logic    clock,
   input wire logic    reset,
   sfpa_req_if.sink    req_ch,
   sfpa_rsp_if.source  rsp_ch
);

   localparam int CW    = sfpa_pkg::fld_width(CARDS);
   localparam int BW    = sfpa_pkg::fld_width(BUSES);
   localparam int HW    = sfpa_pkg::fld_width(CHIPS);
   localparam int KW    = sfpa_pkg::fld_width(BLOCKS);
   localparam int PW    = sfpa_pkg::fld_width(PAGES);
   localparam int AW    = CW + BW + HW + KW;
   localparam int TOTAL = CARDS * BUSES * CHIPS * BLOCKS;
   localparam int NW    = sfpa_pkg::fld_width(TOTAL);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_READ  = 6'b000100,
      S_LOOK  = 6'b001000,
      S_WALK  = 6'b010000,
      S_FIN   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [AW-1:0] clr_ff;

   // latched request word
   sfpa_pkg::mode_type mode_ff;
   logic [CW-1:0] rc_ff;
   logic [BW-1:0] rb_ff;
   logic [HW-1:0] rh_ff;
   logic [KW-1:0] rk_ff;
   logic [PW-1:0] rp_ff;
   logic          fail_ff;

   // working result
   logic [CW-1:0] wc_ff;
   logic [BW-1:0] wb_ff;
   logic [HW-1:0] wh_ff;
   logic [KW-1:0] wk_ff;
   logic [PW-1:0] wp_ff;
   logic          wbad_ff, waw_ff, wne_ff;
   sfpa_pkg::status_type wprior_ff;

   // response register
   logic          rsp_valid_ff;
   logic [CW-1:0] oc_ff;
   logic [BW-1:0] ob_ff;
   logic [HW-1:0] oh_ff;
   logic [KW-1:0] ok_ff;
   logic [PW-1:0] op_ff;
   logic          obad_ff, oaw_ff, one_ff;
   sfpa_pkg::status_type oprior_ff;

   // walk control
   logic          prime_ff;
   logic [NW-1:0] chk_ff;

   logic [CW-1:0] cur_c;
   logic [BW-1:0] cur_b;
   logic [HW-1:0] cur_h;
   logic [KW-1:0] cur_k;
   logic [PW-1:0] cur_p;
   sfpa_pkg::cur_cmd_type cur_cmd;

   logic [AW-1:0] req_addr, cur_addr, mem_raddr, mem_waddr;
   logic          mem_we;
   logic [sfpa_pkg::StatusWidth-1:0] mem_wdata, mem_rdata;
   sfpa_pkg::status_type rd_status;
   logic req_fire, addr_ok, page_last, chk_valid, walk_hit, walk_last, rsp_load;

   sfpa_cursor #(
      .CARDS (CARDS),
      .BUSES (BUSES),
      .CHIPS (CHIPS),
      .BLOCKS(BLOCKS),
      .PAGES (PAGES)
   ) u_cursor (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cur_cmd),
      .cur_card (cur_c),
      .cur_bus  (cur_b),
      .cur_chip (cur_h),
      .cur_block(cur_k),
      .cur_page (cur_p)
   );

   sfpa_status_mem #(
      .AW(AW)
   ) u_mem (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   // address decode and request checks
   assign req_fire  = req_ch.valid && req_ch.ready;
   assign req_addr  = {rk_ff, rh_ff, rb_ff, rc_ff};
   assign cur_addr  = {cur_k, cur_h, cur_b, cur_c};
   assign rd_status = sfpa_pkg::status_type'(mem_rdata);
   assign addr_ok   = ({1'b0, rc_ff} < (CW + 1)'(CARDS)) &&
                      ({1'b0, rb_ff} < (BW + 1)'(BUSES)) &&
                      ({1'b0, rh_ff} < (HW + 1)'(CHIPS)) &&
                      ({1'b0, rk_ff} < (KW + 1)'(BLOCKS));
   assign page_last = (rp_ff == PW'(PAGES - 1));

   // walk check on the status that arrives for the last stepped position
   assign chk_valid = (state_ff == S_WALK) && !prime_ff;
   assign walk_hit  = chk_valid && (rd_status == sfpa_pkg::ST_ERASED);
   assign walk_last = chk_valid && (chk_ff == NW'(TOTAL - 1));
   assign rsp_load  = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ch.ready);

   // memory port steering
   assign mem_raddr = (mode_ff == sfpa_pkg::MODE_ALLOC) ? cur_addr : req_addr;
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = req_addr;
      mem_wdata = sfpa_pkg::ST_UNINIT;
      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
      end else if (state_ff == S_LOOK && addr_ok) begin
         if (mode_ff == sfpa_pkg::MODE_ERASE) begin
            mem_we    = 1'b1;
            mem_wdata = fail_ff ? sfpa_pkg::ST_BAD : sfpa_pkg::ST_ERASED;
         end else if (mode_ff == sfpa_pkg::MODE_WRITE && page_last) begin
            mem_we    = 1'b1;
            mem_wdata = sfpa_pkg::ST_WRITTEN;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cur_cmd  = sfpa_pkg::CUR_HOLD;
      case (state_ff)
         S_CLEAR: begin
            if (&clr_ff) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_fire) state_in = S_READ;
         end
         S_READ: begin
            state_in = S_LOOK;
         end
         S_LOOK: begin
            if (mode_ff == sfpa_pkg::MODE_ALLOC) begin
               cur_cmd  = sfpa_pkg::CUR_STEP;
               state_in = S_WALK;
            end else begin
               state_in = S_FIN;
            end
         end
         S_WALK: begin
            if (walk_hit || walk_last) begin
               cur_cmd  = sfpa_pkg::CUR_BACK;
               state_in = S_FIN;
            end else begin
               cur_cmd  = sfpa_pkg::CUR_STEP;
            end
         end
         S_FIN: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         prime_ff     <= 1'b0;
         chk_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == S_LOOK) begin
            prime_ff <= 1'b1;
            chk_ff   <= '0;
         end else if (state_ff == S_WALK) begin
            prime_ff <= 1'b0;
            if (chk_valid) chk_ff <= chk_ff + 1'b1;
         end
      end
   end

   // capture request word
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff <= sfpa_pkg::mode_type'(req_ch.mode);
         rc_ff   <= req_ch.card;
         rb_ff   <= req_ch.bus;
         rh_ff   <= req_ch.chip;
         rk_ff   <= req_ch.block;
         rp_ff   <= req_ch.page;
         fail_ff <= req_ch.erase_failed;
      end
   end

   // build the working result
   always_ff @(posedge clock) begin
      if (state_ff == S_LOOK) begin
         wc_ff     <= '0;
         wb_ff     <= '0;
         wh_ff     <= '0;
         wk_ff     <= '0;
         wp_ff     <= '0;
         wbad_ff   <= 1'b0;
         waw_ff    <= 1'b0;
         wne_ff    <= 1'b0;
         wprior_ff <= sfpa_pkg::ST_UNINIT;
         case (mode_ff)
            sfpa_pkg::MODE_ALLOC: begin
               wc_ff     <= cur_c;
               wb_ff     <= cur_b;
               wh_ff     <= cur_h;
               wk_ff     <= cur_k;
               wp_ff     <= cur_p;
               wbad_ff   <= (rd_status == sfpa_pkg::ST_BAD);
               wprior_ff <= rd_status;
            end
            sfpa_pkg::MODE_ERASE: begin
               if (addr_ok) wprior_ff <= rd_status;
            end
            sfpa_pkg::MODE_WRITE: begin
               if (addr_ok) begin
                  wprior_ff <= rd_status;
                  waw_ff    <= (rd_status == sfpa_pkg::ST_WRITTEN);
               end
            end
            default: begin
            end
         endcase
      end else if (walk_hit || walk_last) begin
         wne_ff <= !walk_hit;
      end
   end

   // hand the result to the output register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         oc_ff     <= wc_ff;
         ob_ff     <= wb_ff;
         oh_ff     <= wh_ff;
         ok_ff     <= wk_ff;
         op_ff     <= wp_ff;
         obad_ff   <= wbad_ff;
         oaw_ff    <= waw_ff;
         one_ff    <= wne_ff;
         oprior_ff <= wprior_ff;
      end
   end

   assign req_ch.ready           = (state_ff == S_IDLE);
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.alloc_card      = oc_ff;
   assign rsp_ch.alloc_bus       = ob_ff;
   assign rsp_ch.alloc_chip      = oh_ff;
   assign rsp_ch.alloc_block     = ok_ff;
   assign rsp_ch.alloc_page      = op_ff;
   assign rsp_ch.bad_block_hit   = obad_ff;
   assign rsp_ch.already_written = oaw_ff;
   assign rsp_ch.no_erased_block = one_ff;
   assign rsp_ch.prior_status    = oprior_ff;

   // the walk never writes the status memory
   a_walk_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> !mem_we)
      else $error("status memory written during cursor walk");

   // the walk stops within one sweep of all blocks
   a_walk_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (chk_ff <= NW'(TOTAL - 1)))
      else $error("cursor walk exceeded one sweep");

   // a response word only appears out of the finish state
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN))
      else $error("response raised outside finish state");

   // the cursor moves only while an allocate is in progress
   a_cursor_alloc: assert property (@(posedge clock) disable iff (reset)
      (cur_cmd != sfpa_pkg::CUR_HOLD) |-> (mode_ff == sfpa_pkg::MODE_ALLOC))
      else $error("cursor moved outside allocate");

endmodule

`default_nettype wire
